@@ rtl/core/rce_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the step program of the reverb and chorus unit.
// No dependencies; every other file imports this package.

package rce_pkg;

	localparam int DELAY_DEPTH = 16384;
	localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
	localparam int SAMPLE_BITS = 20;
	localparam int WORK_W      = 32;
	localparam int PROD_W      = WORK_W + 9;
	localparam int RF_N        = 15;
	localparam int OUT_N       = 12;
	localparam int PROG_LEN    = 78;
	localparam int PC_W        = $clog2(PROG_LEN);

	typedef struct packed {
		logic                          kind;
		logic [5:0]                    table_index;
		logic [15:0]                   table_word;
		logic [13:0]                   ring_base;
		logic signed [SAMPLE_BITS-1:0] reverb_sample;
		logic signed [SAMPLE_BITS-1:0] chorus_sample;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] send_hi_0;
		logic signed [SAMPLE_BITS-1:0] send_hi_1;
		logic signed [SAMPLE_BITS-1:0] send_hi_2;
		logic signed [SAMPLE_BITS-1:0] send_hi_3;
		logic signed [SAMPLE_BITS-1:0] send_hi_4;
		logic signed [SAMPLE_BITS-1:0] send_hi_5;
		logic signed [SAMPLE_BITS-1:0] send_lo_0;
		logic signed [SAMPLE_BITS-1:0] send_lo_1;
		logic signed [SAMPLE_BITS-1:0] send_lo_2;
		logic signed [SAMPLE_BITS-1:0] send_lo_3;
		logic signed [SAMPLE_BITS-1:0] send_lo_4;
		logic signed [SAMPLE_BITS-1:0] send_lo_5;
	} result_t;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TABLE  = 1'b1;

	localparam logic [1:0] MEM_NONE = 2'd0;
	localparam logic [1:0] MEM_RD   = 2'd1;
	localparam logic [1:0] MEM_RDO  = 2'd2;
	localparam logic [1:0] MEM_WR   = 2'd3;

	localparam logic [1:0] C_HI   = 2'd0;
	localparam logic [1:0] C_LO   = 2'd1;
	localparam logic [1:0] C_ONE  = 2'd2;
	localparam logic [1:0] C_GATE = 2'd3;

	localparam logic [1:0] Y_NONE = 2'd0;
	localparam logic [1:0] Y_ADD  = 2'd1;
	localparam logic [1:0] Y_SUB  = 2'd2;

	localparam logic [4:0] S_A0 = 5'd0;
	localparam logic [4:0] S_A1 = 5'd1;
	localparam logic [4:0] S_A2 = 5'd2;
	localparam logic [4:0] S_A3 = 5'd3;
	localparam logic [4:0] S_A4 = 5'd4;
	localparam logic [4:0] S_A5 = 5'd5;
	localparam logic [4:0] S_B0 = 5'd6;
	localparam logic [4:0] S_B1 = 5'd7;
	localparam logic [4:0] S_B2 = 5'd8;
	localparam logic [4:0] S_B3 = 5'd9;
	localparam logic [4:0] S_B4 = 5'd10;
	localparam logic [4:0] S_B5 = 5'd11;
	localparam logic [4:0] S_T  = 5'd12;
	localparam logic [4:0] S_X  = 5'd13;
	localparam logic [4:0] S_S  = 5'd14;
	localparam logic [4:0] S_M  = 5'd15;
	localparam logic [4:0] S_RV = 5'd16;
	localparam logic [4:0] S_CH = 5'd17;
	localparam logic [4:0] D_HI0  = 5'd18;
	localparam logic [4:0] D_LO0  = 5'd24;
	localparam logic [4:0] D_NONE = 5'd31;

	typedef struct packed {
		logic [1:0] mem;
		logic [5:0] tap;
		logic [5:0] vidx;
		logic [1:0] cs;
		logic [4:0] xs;
		logic [1:0] yop;
		logic [4:0] ys;
		logic       accin;
		logic       keep;
		logic [2:0] sh;
		logic [4:0] dst;
	} uop_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		logic alu_en;
		logic commit;
		uop_t op;
	} ctl_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [WORK_W-1:0] x);
		logic signed [WORK_W-1:0] hi;
		logic signed [WORK_W-1:0] lo;
		hi = WORK_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
		lo = -hi - WORK_W'(1);
		if (x > hi) return hi[SAMPLE_BITS-1:0];
		if (x < lo) return lo[SAMPLE_BITS-1:0];
		return x[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic [5:0] tw(input int row, input int col);
		return 6'((row - 28) * 16 + col);
	endfunction

	function automatic uop_t mk(input logic [1:0] mem, input logic [5:0] tap,
			input logic [5:0] vidx, input logic [1:0] cs, input logic [4:0] xs,
			input logic [1:0] yop, input logic [4:0] ys, input logic accin,
			input logic keep, input logic [2:0] sh, input logic [4:0] dst);
		uop_t u;
		u.mem = mem; u.tap = tap; u.vidx = vidx; u.cs = cs; u.xs = xs;
		u.yop = yop; u.ys = ys; u.accin = accin; u.keep = keep; u.sh = sh;
		u.dst = dst;
		return u;
	endfunction

	function automatic uop_t am(input logic [1:0] mem, input logic [5:0] tap,
			input logic [5:0] v, input logic [1:0] cs, input logic [4:0] xs,
			input logic [2:0] sh, input logic [1:0] yop, input logic [4:0] ys,
			input logic [4:0] dst);
		return mk(mem, tap, v, cs, xs, yop, ys, 1'b0, 1'b0, sh, dst);
	endfunction

	function automatic uop_t al(input logic [5:0] v, input logic [1:0] cs,
			input logic [4:0] xs, input logic [2:0] sh, input logic [1:0] yop,
			input logic [4:0] ys, input logic [4:0] dst);
		return am(MEM_NONE, 6'd0, v, cs, xs, sh, yop, ys, dst);
	endfunction

	function automatic uop_t ld(input logic [1:0] mem, input logic [5:0] tap,
			input logic [1:0] yop, input logic [4:0] ys, input logic [4:0] dst);
		return am(mem, tap, 6'd0, C_ONE, S_M, 3'd0, yop, ys, dst);
	endfunction

	function automatic uop_t mv(input logic [4:0] xs, input logic [1:0] yop,
			input logic [4:0] ys, input logic [4:0] dst);
		return al(6'd0, C_ONE, xs, 3'd0, yop, ys, dst);
	endfunction

	function automatic uop_t st(input logic [5:0] tap, input logic [4:0] xs);
		return mk(MEM_WR, tap, 6'd0, C_ONE, xs, Y_NONE, S_A0, 1'b0, 1'b0, 3'd0, D_NONE);
	endfunction

	function automatic uop_t kp(input logic [5:0] v, input logic [1:0] cs,
			input logic [4:0] xs);
		return mk(MEM_NONE, 6'd0, v, cs, xs, Y_NONE, S_A0, 1'b0, 1'b1, 3'd0, D_NONE);
	endfunction

	function automatic uop_t ac(input logic [1:0] mem, input logic [5:0] tap,
			input logic [5:0] v, input logic [1:0] cs, input logic [4:0] xs,
			input logic [4:0] dst);
		return mk(mem, tap, v, cs, xs, Y_NONE, S_A0, 1'b1, 1'b0, 3'd6, dst);
	endfunction

	function automatic uop_t prog_op(input logic [PC_W-1:0] pc);
		uop_t u;
		unique case (pc)
			0:  u = kp(tw(31, 1), C_HI, S_B1);
			1:  u = ac(MEM_NONE, 6'd0, tw(31, 1), C_LO, S_CH, S_B1);
			2:  u = kp(tw(30, 1), C_HI, S_B0);
			3:  u = ac(MEM_NONE, 6'd0, tw(30, 1), C_LO, S_RV, S_B0);
			4:  u = al(tw(30, 4), C_HI, S_B0, 3'd6, Y_NONE, S_A0, S_T);
			5:  u = am(MEM_RD, tw(28, 1), tw(30, 4), C_GATE, S_M, 3'd1, Y_SUB, S_T, S_B4);
			6:  u = al(tw(30, 4), C_LO, S_B4, 3'd6, Y_ADD, S_M, S_B5);
			7:  u = am(MEM_RD, tw(28, 2), tw(30, 4), C_GATE, S_M, 3'd1, Y_SUB, S_B5, S_B5);
			8:  u = al(tw(30, 4), C_LO, S_B5, 3'd6, Y_ADD, S_M, S_A0);
			9:  u = am(MEM_RD, tw(28, 3), tw(30, 4), C_GATE, S_M, 3'd1, Y_SUB, S_A0, S_A0);
			10: u = al(tw(30, 4), C_LO, S_A0, 3'd6, Y_ADD, S_M, S_A1);
			11: u = ld(MEM_RD, tw(28, 5), Y_NONE, S_A0, S_A2);
			12: u = am(MEM_RD, tw(28, 4), tw(30, 5), C_GATE, S_M, 3'd1, Y_SUB, S_A1, S_A1);
			13: u = al(tw(30, 5), C_LO, S_A1, 3'd6, Y_ADD, S_M, S_A3);
			14: u = ld(MEM_RD, tw(29, 1), Y_NONE, S_A0, S_A4);
			15: u = kp(tw(30, 7), C_HI, S_B2);
			16: u = ac(MEM_RD, tw(29, 0), tw(30, 7), C_LO, S_M, S_B2);
			17: u = st(tw(28, 0), S_B4);
			18: u = kp(tw(30, 8), C_HI, S_B3);
			19: u = ac(MEM_RD, tw(29, 8), tw(30, 8), C_LO, S_M, S_B3);
			20: u = st(tw(28, 1), S_B5);
			21: u = st(tw(28, 2), S_A0);
			22: u = mv(S_A3, Y_NONE, S_A0, S_X);
			23: u = al(tw(30, 9), C_HI, S_B2, 3'd6, Y_ADD, S_X, S_A3);
			24: u = al(tw(30, 9), C_HI, S_B3, 3'd6, Y_ADD, S_X, S_A5);
			25: u = st(tw(28, 3), S_A1);
			26: u = al(tw(30, 6), C_HI, S_A2, 3'd6, Y_ADD, S_A3, S_A3);
			27: u = al(tw(30, 6), C_LO, S_A3, 3'd6, Y_ADD, S_A2, S_A2);
			28: u = ld(MEM_RD, tw(28, 9), Y_NONE, S_A0, S_A1);
			29: u = al(tw(30, 6), C_HI, S_A4, 3'd6, Y_ADD, S_A5, S_A5);
			30: u = al(tw(30, 6), C_LO, S_A5, 3'd6, Y_ADD, S_A4, S_A4);
			31: u = ld(MEM_RD, tw(29, 5), Y_NONE, S_A0, S_B4);
			32: u = mv(S_A1, Y_NONE, S_A0, S_X);
			33: u = am(MEM_RD, tw(28, 8), tw(30, 6), C_HI, S_X, 3'd6, Y_ADD, S_M, S_A1);
			34: u = al(tw(30, 6), C_LO, S_A1, 3'd6, Y_ADD, S_X, S_B5);
			35: u = st(tw(28, 4), S_A3);
			36: u = mv(S_B4, Y_NONE, S_A0, S_X);
			37: u = am(MEM_RD, tw(29, 4), tw(30, 6), C_HI, S_X, 3'd6, Y_ADD, S_M, S_B4);
			38: u = al(tw(30, 6), C_LO, S_B4, 3'd6, Y_ADD, S_X, S_A0);
			39: u = st(tw(28, 5), S_A2);
			40: u = st(tw(29, 0), S_A5);
			41: u = ld(MEM_RD, tw(28, 6), Y_NONE, S_A0, S_A5);
			42: u = ld(MEM_RD, tw(28, 10), Y_ADD, S_A5, S_A5);
			43: u = ld(MEM_RD, tw(29, 2), Y_NONE, S_A0, S_A2);
			44: u = ld(MEM_RD, tw(29, 6), Y_ADD, S_A5, S_A5);
			45: u = mv(S_A2, Y_ADD, S_A5, S_A5);
			46: u = ld(MEM_RD, tw(28, 7), Y_NONE, S_A0, S_A2);
			47: u = ld(MEM_RD, tw(28, 11), Y_ADD, S_A2, S_A2);
			48: u = ld(MEM_RD, tw(29, 3), Y_NONE, S_A0, S_A3);
			49: u = ld(MEM_RD, tw(29, 7), Y_ADD, S_A2, S_A2);
			50: u = mv(S_A3, Y_ADD, S_A2, S_A2);
			51: u = st(tw(29, 1), S_A4);
			52: u = st(tw(28, 8), S_A1);
			53: u = al(tw(30, 2), C_HI, S_A5, 3'd5, Y_NONE, S_A0, D_HI0);
			54: u = al(tw(30, 2), C_LO, S_A5, 3'd5, Y_NONE, S_A0, D_LO0);
			55: u = ld(MEM_RDO, tw(29, 10), Y_NONE, S_A0, S_T);
			56: u = st(tw(28, 9), S_B5);
			57: u = mv(S_T, Y_NONE, S_A0, S_B5);
			58: u = al(tw(30, 3), C_HI, S_A2, 3'd5, Y_NONE, S_A0, D_HI0 + 5'd1);
			59: u = al(tw(30, 3), C_LO, S_A2, 3'd5, Y_NONE, S_A0, D_LO0 + 5'd1);
			60: u = ld(MEM_RDO, tw(29, 11), Y_NONE, S_A0, S_A1);
			61: u = ld(MEM_RD, tw(29, 10), Y_NONE, S_A0, S_S);
			62: u = st(tw(29, 4), S_B4);
			63: u = al(tw(31, 9), C_HI, S_S, 3'd6, Y_SUB, S_S, S_T);
			64: u = al(tw(31, 9), C_HI, S_B5, 3'd6, Y_ADD, S_T, S_B5);
			65: u = ld(MEM_RD, tw(29, 11), Y_NONE, S_A0, S_S);
			66: u = st(tw(29, 5), S_A0);
			67: u = al(tw(31, 10), C_HI, S_S, 3'd6, Y_SUB, S_S, S_T);
			68: u = al(tw(31, 10), C_HI, S_A1, 3'd6, Y_ADD, S_T, S_A1);
			69: u = st(tw(29, 9), S_B1);
			70: u = al(tw(31, 2), C_HI, S_B5, 3'd5, Y_NONE, S_A0, D_HI0 + 5'd2);
			71: u = al(tw(31, 2), C_LO, S_B5, 3'd5, Y_NONE, S_A0, D_LO0 + 5'd2);
			72: u = al(tw(31, 3), C_HI, S_B5, 3'd5, Y_NONE, S_A0, D_HI0 + 5'd3);
			73: u = al(tw(31, 3), C_LO, S_B5, 3'd5, Y_NONE, S_A0, D_LO0 + 5'd3);
			74: u = al(tw(31, 4), C_HI, S_A1, 3'd5, Y_NONE, S_A0, D_HI0 + 5'd4);
			75: u = al(tw(31, 4), C_LO, S_A1, 3'd5, Y_NONE, S_A0, D_LO0 + 5'd4);
			76: u = al(tw(31, 5), C_HI, S_A1, 3'd5, Y_NONE, S_A0, D_HI0 + 5'd5);
			77: u = al(tw(31, 5), C_LO, S_A1, 3'd5, Y_NONE, S_A0, D_LO0 + 5'd5);
			default: u = st(6'd0, S_A0) ^ st(6'd0, S_A0);
		endcase
		return u;
	endfunction

endpackage

@@ rtl/core/rce_core.sv @@
`timescale 1ns / 1ps
// Arithmetic core: working registers, shared multiplier, accumulator and send stage.
// Depends on rce_pkg.

module rce_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rce_pkg::ctl_t                          ctl,
	input  logic signed [rce_pkg::SAMPLE_BITS-1:0] rev_in,
	input  logic signed [rce_pkg::SAMPLE_BITS-1:0] cho_in,
	input  logic [15:0]                            coef,
	input  logic signed [rce_pkg::SAMPLE_BITS-1:0] mem_rd,
	output logic signed [rce_pkg::SAMPLE_BITS-1:0] mem_wd,
	output rce_pkg::result_t                       sends
);
	import rce_pkg::*;

	logic signed [WORK_W-1:0]      rf_q [RF_N];
	logic signed [SAMPLE_BITS-1:0] rev_q, cho_q;
	logic signed [SAMPLE_BITS-1:0] snd_q [OUT_N];
	logic signed [PROD_W-1:0]      prod_s1, acc_q;
	logic signed [WORK_W-1:0]      xval, yval, fval, res;
	logic signed [7:0]             cval;
	logic signed [PROD_W-1:0]      sum, shifted;

	always_comb begin
		xval = '0;
		if (ctl.op.xs < S_M) begin
			xval = rf_q[ctl.op.xs[3:0]];
		end else begin
			case (ctl.op.xs)
				S_M:     xval = WORK_W'(mem_rd);
				S_RV:    xval = WORK_W'(rev_q);
				S_CH:    xval = WORK_W'(cho_q);
				default: xval = '0;
			endcase
		end
	end

	always_comb begin
		yval = '0;
		if (ctl.op.ys < S_M) begin
			yval = rf_q[ctl.op.ys[3:0]];
		end else begin
			case (ctl.op.ys)
				S_M:     yval = WORK_W'(mem_rd);
				S_RV:    yval = WORK_W'(rev_q);
				S_CH:    yval = WORK_W'(cho_q);
				default: yval = '0;
			endcase
		end
	end

	always_comb begin
		unique case (ctl.op.cs)
			C_HI:   cval = coef[15:8];
			C_LO:   cval = coef[7:0];
			C_ONE:  cval = 8'sd1;
			C_GATE: cval = (|coef[5:4]) ? 8'sd1 : 8'sd0;
		endcase
	end

	assign sum     = (ctl.op.accin ? acc_q : '0) + prod_s1;
	assign shifted = sum >>> ctl.op.sh;
	assign fval    = shifted[WORK_W-1:0];

	always_comb begin
		unique case (ctl.op.yop)
			Y_ADD:   res = yval + fval;
			Y_SUB:   res = yval - fval;
			default: res = fval;
		endcase
	end

	assign mem_wd = sat(xval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RF_N; i++) rf_q[i] <= '0;
		end else begin
			if (ctl.alu_en && !ctl.op.keep && ctl.op.dst < S_M) begin
				rf_q[ctl.op.dst[3:0]] <= res;
			end
			if (ctl.commit) begin
				for (int i = 0; i < 12; i++) rf_q[i] <= WORK_W'(sat(rf_q[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rev_q <= rev_in;
			cho_q <= cho_in;
		end
		if (ctl.mul_en) begin
			prod_s1 <= PROD_W'(xval) * PROD_W'(cval);
		end
		if (ctl.alu_en && ctl.op.keep) begin
			acc_q <= sum;
		end
		if (ctl.alu_en && !ctl.op.keep && ctl.op.dst >= D_HI0 && ctl.op.dst < D_NONE) begin
			snd_q[4'(ctl.op.dst - D_HI0)] <= sat(res);
		end
	end

	assign sends.send_hi_0 = snd_q[0];
	assign sends.send_hi_1 = snd_q[1];
	assign sends.send_hi_2 = snd_q[2];
	assign sends.send_hi_3 = snd_q[3];
	assign sends.send_hi_4 = snd_q[4];
	assign sends.send_hi_5 = snd_q[5];
	assign sends.send_lo_0 = snd_q[6];
	assign sends.send_lo_1 = snd_q[7];
	assign sends.send_lo_2 = snd_q[8];
	assign sends.send_lo_3 = snd_q[9];
	assign sends.send_lo_4 = snd_q[10];
	assign sends.send_lo_5 = snd_q[11];

endmodule

@@ rtl/core/reverb_chorus_effect_step_unit.sv @@
`timescale 1ns / 1ps
// Top level of the reverb and chorus unit: sequencer, delay store and coefficient table.
// Depends on rce_pkg and rce_core.
//
// The item channel carries either a table-write beat or a sample beat. A table-write
// beat stores one 16-bit word into the 64-word coefficient table and gives no
// result. A sample beat runs a fixed program of 78 steps over the 16K-word
// delay store; each step passes through table read of the tap word, delay
// read or write, multiply and accumulate, so the result beat is raised once the
// last step is done, and the next item can be taken once the result is handed to
// the output register. The single port of the delay store and the one
// shared multiplier bound the sample rate. The block takes one item at a time and
// stalls the item channel while a sample is in work.
// The result beat sits in an output register; the next item is taken while it
// waits, and a finished sample holds until the receiver drops its stall.
// After reset the block clears the delay store and the table, one word a cycle,
// over its 16384 addresses, and keeps the item channel stalled until that pass is over.

module reverb_chorus_effect_step_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  rce_pkg::item_t     item,
	output logic               result_valid,
	input  logic               result_stall,
	output rce_pkg::result_t   result
);
	import rce_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [1:0] PH_TAP  = 2'd0;
	localparam logic [1:0] PH_ADDR = 2'd1;
	localparam logic [1:0] PH_MUL  = 2'd2;
	localparam logic [1:0] PH_ALU  = 2'd3;

	logic [1:0]                    state_q, ph_q;
	logic [PC_W-1:0]               pc_q;
	logic [DELAY_AW-1:0]           clr_q;
	logic [13:0]                   ring_q;
	logic [15:0]                   cmem [64];
	logic [15:0]                   crd_q;
	logic signed [SAMPLE_BITS-1:0] dmem [DELAY_DEPTH];
	logic signed [SAMPLE_BITS-1:0] drd_q;
	logic signed [SAMPLE_BITS-1:0] mem_wd;
	logic [DELAY_AW-1:0]           daddr;
	logic                          take, running, dwe_run, drd_en, hand_off, last_step;
	uop_t                          op;
	ctl_t                          ctl;
	result_t                       sends;
	result_t                       result_q;
	logic                          result_valid_q;

	assign op         = prog_op(pc_q);
	assign item_stall = (state_q != ST_IDLE);
	assign take       = item_valid && !item_stall;
	assign running    = (state_q == ST_RUN);
	assign last_step  = (pc_q == PC_W'(PROG_LEN - 1));
	assign hand_off   = (state_q == ST_DONE) && (!result_valid_q || !result_stall);

	assign daddr = DELAY_AW'(crd_q) + DELAY_AW'(ring_q) + DELAY_AW'(op.mem == MEM_RDO);
	assign dwe_run = running && (ph_q == PH_ADDR) && (op.mem == MEM_WR);
	assign drd_en  = running && (ph_q == PH_ADDR) && (op.mem == MEM_RD || op.mem == MEM_RDO);

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			cmem[clr_q[5:0]] <= '0;
		end else if (take && item.kind == KIND_TABLE) begin
			cmem[item.table_index] <= item.table_word;
		end
		if (running && ph_q == PH_TAP) begin
			crd_q <= cmem[op.tap];
		end else if (running && ph_q == PH_ADDR) begin
			crd_q <= cmem[op.vidx];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			dmem[clr_q] <= '0;
		end else if (dwe_run) begin
			dmem[daddr] <= mem_wd;
		end
		if (drd_en) begin
			drd_q <= dmem[daddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			ph_q           <= PH_TAP;
			pc_q           <= '0;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= hand_off || (result_valid_q && result_stall);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + DELAY_AW'(1);
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (take && item.kind == KIND_SAMPLE) begin
						pc_q    <= '0;
						ph_q    <= PH_TAP;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == PH_ALU) begin
						if (last_step) state_q <= ST_DONE;
						else pc_q <= pc_q + PC_W'(1);
					end
				end
				ST_DONE: begin
					if (hand_off) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.kind == KIND_SAMPLE) ring_q <= item.ring_base;
		if (hand_off) result_q <= sends;
	end

	assign ctl.load   = take && item.kind == KIND_SAMPLE;
	assign ctl.mul_en = running && ph_q == PH_MUL;
	assign ctl.alu_en = running && ph_q == PH_ALU;
	assign ctl.commit = running && ph_q == PH_ALU && last_step;
	assign ctl.op     = op;

	rce_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rev_in (item.reverb_sample),
		.cho_in (item.chorus_sample),
		.coef   (crd_q),
		.mem_rd (drd_q),
		.mem_wd (mem_wd),
		.sends  (sends)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == ST_DONE)
		else $error("result beat raised outside the done state");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		running |-> pc_q < PC_W'(PROG_LEN))
		else $error("program counter ran past the last step");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(running || state_q == ST_CLEAR) |-> !take)
		else $error("item taken while the sequencer is busy");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		dwe_run |-> (ph_q == PH_ADDR && !drd_en))
		else $error("delay write outside its step phase");

endmodule
